/* rtl/core/shb_pkg.sv */
// Shared types, constants and round functions for the SHA-256 byte stream hasher.
package shb_pkg;

	// Default depth of the command queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int WORD_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int BLOCK_W = 512;
	localparam int LEN_W   = 64;
	localparam int POS_W   = 6;
	localparam int ROUND_W = 6;

	localparam logic [POS_W-1:0]   POS_LAST   = 6'd63;
	localparam logic [POS_W-1:0]   POS_LEN    = 6'd56;
	localparam logic [ROUND_W-1:0] ROUND_LAST = 6'd63;
	localparam logic [BYTE_W-1:0]  PAD_MARK   = 8'h80;
	localparam logic [LEN_W-1:0]   BITS_PER_BYTE = 64'd8;

	// Round constants
	localparam logic [WORD_W-1:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Initial chaining values
	localparam logic [WORD_W-1:0] INIT_H [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// One queued command: a data byte and/or the end-of-message mark
	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              present;
		logic              last;
	} cmd_t;

	// Back-end status seen by the top level
	typedef struct packed {
		logic in_rounds;
		logic round_last;
		logic in_add;
	} status_t;

	// Back-end sequencer states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ROUND = 5'b00010,
		ST_ADD   = 5'b00100,
		ST_PAD   = 5'b01000,
		ST_OUT   = 5'b10000
	} back_state_t;

	function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
		rotr = (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic logic [WORD_W-1:0] big_sig0(input logic [WORD_W-1:0] x);
		big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [WORD_W-1:0] big_sig1(input logic [WORD_W-1:0] x);
		big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [WORD_W-1:0] sml_sig0(input logic [WORD_W-1:0] x);
		sml_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [WORD_W-1:0] sml_sig1(input logic [WORD_W-1:0] x);
		sml_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

/* rtl/core/shb_front.sv */
// Input stage: takes byte beats, drops beats that carry nothing, stages commands.
module shb_front
	import shb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] message_byte
	input  logic [0:0]  s_tuser,   // [0] byte_present
	input  logic        s_tlast,   // message_end
	output logic        push,
	output cmd_t        push_data,
	input  logic        q_full
);

	logic       cmd_vld_s1;
	cmd_t       cmd_s1;
	logic       keep;

	// A beat with no byte and no end mark is a no-op
	assign keep     = s_tuser[0] | s_tlast;
	assign push     = cmd_vld_s1 & ~q_full;
	assign s_tready = ~cmd_vld_s1 | ~q_full;
	assign push_data = cmd_s1;

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			cmd_vld_s1 <= s_tvalid & keep;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1.data    <= s_tdata;
			cmd_s1.present <= s_tuser[0];
			cmd_s1.last    <= s_tlast;
		end
	end

endmodule

/* rtl/core/shb_queue.sv */
// Small command queue between the input stage and the hashing back end.
module shb_queue
	import shb_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
)(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output cmd_t pop_data,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/core/shb_back.sv */
// Back end: block assembly, padding, 64-round compression and digest output.
module shb_back
	import shb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	output logic        pop,
	input  cmd_t        pop_data,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic        m_tlast,   // digest_last
	output status_t     status
);

	back_state_t          state_q;
	logic [BLOCK_W-1:0]   blk_q;
	logic [POS_W-1:0]     pos_q;
	logic [LEN_W-1:0]     bit_cnt_q;
	logic [ROUND_W-1:0]   round_q;
	logic [WORD_W-1:0]    var_q   [8];
	logic [WORD_W-1:0]    chain_q [8];
	logic                 pad_act_q;
	logic                 sent80_q;
	logic                 len_phase_q;
	logic [2:0]           len_cnt_q;
	logic                 len_done_q;
	logic [2:0]           out_idx_q;
	logic                 m_vld_q;
	logic [WORD_W-1:0]    m_word_q;
	logic                 m_last_q;

	logic                 ins_en;
	logic [BYTE_W-1:0]    ins_byte;
	logic                 wrap;
	logic                 take_len;
	logic [BYTE_W-1:0]    pad_byte;
	logic                 out_load;
	logic [WORD_W-1:0]    w0, w1, w9, w14, w_new;
	logic [WORD_W-1:0]    t1, t2;

	// Padding byte: marker, zero fill up to the length field, then length MSB first
	assign take_len = sent80_q & (len_phase_q | (pos_q == POS_LEN));
	always_comb begin
		if (!sent80_q) begin
			pad_byte = PAD_MARK;
		end else if (take_len) begin
			pad_byte = bit_cnt_q[LEN_W-1 -: BYTE_W];
		end else begin
			pad_byte = '0;
		end
	end

	// Byte insertion into the block shift register
	assign pop      = (state_q == ST_IDLE) & ~q_empty;
	assign ins_en   = (pop & pop_data.present) | (state_q == ST_PAD);
	assign ins_byte = (state_q == ST_PAD) ? pad_byte : pop_data.data;
	assign wrap     = ins_en & (pos_q == POS_LAST);

	// Rolling message schedule: word 0 sits at the top of the block register
	assign w0    = blk_q[BLOCK_W-1           -: WORD_W];
	assign w1    = blk_q[BLOCK_W-1-WORD_W    -: WORD_W];
	assign w9    = blk_q[BLOCK_W-1-9*WORD_W  -: WORD_W];
	assign w14   = blk_q[BLOCK_W-1-14*WORD_W -: WORD_W];
	assign w_new = sml_sig1(w14) + w9 + sml_sig0(w1) + w0;

	// One compression round
	assign t1 = var_q[7] + big_sig1(var_q[4])
		+ ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]))
		+ ROUND_K[round_q] + w0;
	assign t2 = big_sig0(var_q[0])
		+ ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));

	assign out_load = (state_q == ST_OUT) & (~m_vld_q | m_tready);

	// Sequencer and message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			bit_cnt_q   <= '0;
			round_q     <= '0;
			pad_act_q   <= 1'b0;
			sent80_q    <= 1'b0;
			len_phase_q <= 1'b0;
			len_cnt_q   <= '0;
			len_done_q  <= 1'b0;
			out_idx_q   <= '0;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_H[i];
			end
		end else begin
			if (ins_en) begin
				pos_q <= pos_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						pad_act_q <= pop_data.last;
						if (pop_data.present) begin
							bit_cnt_q <= bit_cnt_q + BITS_PER_BYTE;
						end
						if (wrap) begin
							state_q <= ST_ROUND;
						end else if (pop_data.last) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					sent80_q <= 1'b1;
					if (take_len) begin
						len_phase_q <= 1'b1;
						bit_cnt_q   <= bit_cnt_q << BYTE_W;
						len_cnt_q   <= len_cnt_q + 1'b1;
						if (len_cnt_q == 3'd7) begin
							len_done_q <= 1'b1;
						end
					end
					if (wrap) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 1'b1;
					if (round_q == ROUND_LAST) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) begin
						chain_q[i] <= chain_q[i] + var_q[i];
					end
					if (!pad_act_q) begin
						state_q <= ST_IDLE;
					end else if (len_done_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_idx_q <= out_idx_q + 1'b1;
						// Last word handed off: back to the start of a message
						if (out_idx_q == 3'd7) begin
							state_q     <= ST_IDLE;
							bit_cnt_q   <= '0;
							pad_act_q   <= 1'b0;
							sent80_q    <= 1'b0;
							len_phase_q <= 1'b0;
							len_cnt_q   <= '0;
							len_done_q  <= 1'b0;
							for (int i = 0; i < 8; i++) begin
								chain_q[i] <= INIT_H[i];
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Block buffer and working variables
	always_ff @(posedge clk) begin
		if (ins_en) begin
			blk_q <= {blk_q[BLOCK_W-BYTE_W-1:0], ins_byte};
		end else if (state_q == ST_ROUND) begin
			blk_q <= {blk_q[BLOCK_W-WORD_W-1:0], w_new};
		end
		if (wrap) begin
			for (int i = 0; i < 8; i++) begin
				var_q[i] <= chain_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + t2;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (out_load) begin
			m_vld_q <= 1'b1;
		end else if (m_tready) begin
			m_vld_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_word_q <= chain_q[out_idx_q];
			m_last_q <= (out_idx_q == 3'd7);
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = m_word_q;
	assign m_tlast  = m_last_q;

	assign status.in_rounds  = (state_q == ST_ROUND);
	assign status.round_last = (round_q == ROUND_LAST);
	assign status.in_add     = (state_q == ST_ADD);

endmodule

/* rtl/core/sha256_byte_stream_hasher_unit.sv */
// SHA-256 over a byte stream: one message byte per beat in, eight digest words out.
// Throughput: one byte a cycle into the block buffer while the back end is idle; each full
//   64-byte block then holds intake for 64 rounds and one add in the shared round unit.
// Latency: the end beat adds the padding bytes (marker, zero fill, length) and one or two compressions,
//   then the eight digest beats (one a cycle when the sink is ready), behind the front stage and the queue.
// Reset: arst_n asynchronous, active low; chaining words to the initial values, counts and
//   queue cleared; the block buffer is not cleared and needs no clearing pass.
module sha256_byte_stream_hasher_unit
	import shb_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] message_byte
	input  logic [0:0]  s_tuser,   // [0] byte_present
	input  logic        s_tlast,   // message_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic        m_tlast    // digest_last
);

	logic    q_push;
	cmd_t    q_push_data;
	logic    q_full;
	logic    q_pop;
	cmd_t    q_pop_data;
	logic    q_empty;
	status_t back_status;

	shb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.push      (q_push),
		.push_data (q_push_data),
		.q_full    (q_full)
	);

	shb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.empty     (q_empty)
	);

	shb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.pop      (q_pop),
		.pop_data (q_pop_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.status   (back_status)
	);

	// Front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("command pushed into full queue");

	// Final round is always followed by the chaining add
	a_round_to_add: assert property (@(posedge clk) disable iff (!arst_n)
		back_status.in_rounds && back_status.round_last |=> back_status.in_add)
		else $error("compression did not end in the add cycle");

	// After the last digest beat no further beat follows at once
	a_digest_gap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid)
		else $error("digest beat right after the final word");

endmodule

/* tb/sv/tb_sha256_byte_stream_hasher_unit.sv */
// Self-checking testbench for the SHA-256 byte stream hasher with a digest scoreboard.
`timescale 1ns / 100ps

module tb_sha256_byte_stream_hasher_unit;

	// SHA-256 round constants and initial chaining words
	localparam logic [31:0] SHA_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] SHA_H0 [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};
	localparam logic [7:0] PAD_BYTE     = 8'h80;
	localparam logic [5:0] LEN_FIELD_AT = 6'd56;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 700;
	localparam int HOLD_MESSAGES  = 12;
	localparam int DRAIN_CYCLES   = 300;
	localparam int ITEM_TARGET    = 430;
	localparam int PHASE_ITEMS    = (ITEM_TARGET - 60) / 4;   // per random phase
	localparam int NOISE_PCT      = 8;

	typedef struct packed {
		logic [31:0] word;
		logic        last;
	} digest_beat_t;

	// Digest predictor plus queue of expected output beats
	class digest_scoreboard;
		logic [31:0]  chain_h [8];
		logic [31:0]  msg_block [16];
		logic [63:0]  msg_bits;
		logic [5:0]   fill_pos;
		digest_beat_t digests_due [$];
		int           fail_count;
		int           words_checked;

		function new();
			fail_count    = 0;
			words_checked = 0;
			restart();
		endfunction

		function void restart();
			for (int i = 0; i < 8; i++)
				chain_h[i] = SHA_H0[i];
			msg_bits = '0;
			fill_pos = '0;
		endfunction

		function logic [31:0] ror(input logic [31:0] x, input int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		// One 64-round compression of the buffered block into the chain
		function void compress();
			logic [31:0] sched [64];
			logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
			for (int r = 0; r < 16; r++)
				sched[r] = msg_block[r];
			for (int r = 16; r < 64; r++) begin
				s0 = ror(sched[r-15], 7) ^ ror(sched[r-15], 18) ^ (sched[r-15] >> 3);
				s1 = ror(sched[r-2], 17) ^ ror(sched[r-2], 19) ^ (sched[r-2] >> 10);
				sched[r] = s1 + sched[r-7] + s0 + sched[r-16];
			end
			a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
			e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
			for (int r = 0; r < 64; r++) begin
				t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
					+ SHA_K[r] + sched[r];
				t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
				h = g; g = f; f = e; e = d + t1;
				d = c; c = b; b = a; a = t1 + t2;
			end
			chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
			chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
		endfunction

		// Big-endian byte placement; a full block compresses right away
		function void put_byte(input logic [7:0] data);
			int wi;
			int sh;
			wi = fill_pos[5:2];
			sh = 8 * (3 - fill_pos[1:0]);
			if (fill_pos[1:0] == 2'd0)
				msg_block[wi] = '0;
			msg_block[wi][sh +: 8] = data;
			fill_pos = fill_pos + 6'd1;
			if (fill_pos == 6'd0)
				compress();
		endfunction

		// Accepted input beat; an end beat pads and queues the eight digest words
		function void note_beat(input logic [7:0] data, input logic present, input logic last);
			logic [63:0]  len;
			digest_beat_t beat;
			if (present) begin
				put_byte(data);
				msg_bits = msg_bits + 64'd8;
			end
			if (last) begin
				len = msg_bits;
				put_byte(PAD_BYTE);
				while (fill_pos != LEN_FIELD_AT)
					put_byte(8'h00);
				for (int i = 7; i >= 0; i--)
					put_byte(len[8*i +: 8]);
				for (int k = 0; k < 8; k++) begin
					beat.word = chain_h[k];
					beat.last = (k == 7);
					digests_due.insert(digests_due.size(), beat);
				end
				restart();
			end
		endfunction

		// Output beat against the oldest expected digest word
		function void check_beat(input logic [31:0] word, input logic last);
			digest_beat_t want;
			if (digests_due.size() == 0) begin
				$display("%0t: unexpected digest beat word=%h last=%b", $time, word, last);
				fail_count++;
			end else begin
				want = digests_due.pop_front();
				words_checked++;
				if (word !== want.word) begin
					$display("%0t: digest_word mismatch expected=%h actual=%h",
						$time, want.word, word);
					fail_count++;
				end
				if (last !== want.last) begin
					$display("%0t: digest_last mismatch expected=%b actual=%b",
						$time, want.last, last);
					fail_count++;
				end
			end
		endfunction

		function int words_pending();
			return digests_due.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tlast;

	digest_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	bit hold_requested;
	int items_sent;
	int messages_sent;
	int bytes_in;
	int ignored_in;
	int quiet_cycles;

	sha256_byte_stream_hasher_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Sink side: random stalls, or a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requested) begin
				hold_requested = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Beat monitor, scoreboard hookup and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_beat(s_tdata, s_tuser[0], s_tlast);
				if (s_tuser[0])
					bytes_in++;
				else if (!s_tlast)
					ignored_in++;
			end
			if (m_tvalid && m_tready)
				sb.check_beat(m_tdata, m_tlast);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d digest words still pending",
					$time, sb.words_pending());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// One input beat; holds valid until the block takes it
	task automatic send_beat(input logic [7:0] data, input logic present, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= present;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Random-content message; the end mark rides on the last byte or on an empty beat
	task automatic send_message(input int len, input bit end_on_byte);
		logic [7:0] data;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < NOISE_PCT)
				send_beat(8'($urandom), 1'b0, 1'b0);
			data = 8'($urandom);
			send_beat(data, 1'b1, end_on_byte && (i == len - 1));
		end
		if (!(end_on_byte && len > 0))
			send_beat(8'($urandom), 1'b0, 1'b1);
		messages_sent++;
	endtask

	function automatic int pick_length();
		int sel;
		int edges [8];
		edges = '{55, 56, 57, 63, 64, 65, 119, 120};
		sel = $urandom_range(99);
		if (sel < 70)
			return $urandom_range(8);
		else if (sel < 85)
			return edges[$urandom_range(7)];
		else if (sel < 95)
			return $urandom_range(40, 9);
		else
			return $urandom_range(130, 100);
	endfunction

	// Sender goes quiet until every queued digest word has left
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.words_pending() != 0)
			@(posedge clk);
	endtask

	// Random messages up to the phase's beat budget
	task automatic run_phase(input int idle_pct, input int stall_pct);
		int items_start;
		int len;
		int room;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		items_start = items_sent;
		while (items_sent - items_start < PHASE_ITEMS) begin
			len  = pick_length();
			room = PHASE_ITEMS - (items_sent - items_start);
			if (len > room)
				len = room;
			send_message(len, $urandom_range(1));
		end
		wait_drained();
	endtask

	initial begin
		sb = new();
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		s_tlast        = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_requested = 1'b0;
		items_sent     = 0;
		messages_sent  = 0;
		bytes_in       = 0;
		ignored_in     = 0;
		quiet_cycles   = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, "abc" both ways, extreme bytes, ignored beats
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'hff, 1'b0, 1'b0);
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b1);
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b0);
		send_beat(8'h5a, 1'b0, 1'b1);
		send_beat(8'hff, 1'b1, 1'b0);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'h00, 1'b0, 1'b0);
		send_beat(8'ha5, 1'b0, 1'b1);
		send_beat(8'hff, 1'b1, 1'b1);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'hff, 1'b0, 1'b1);
		send_beat(8'h80, 1'b1, 1'b0);
		send_beat(8'h7f, 1'b1, 1'b0);
		send_beat(8'h55, 1'b1, 1'b0);
		send_beat(8'haa, 1'b1, 1'b1);
		messages_sent += 7;
		wait_drained();

		// Sink held off while short messages pile up and back-pressure the input
		hold_requested = 1'b1;
		for (int m = 0; m < HOLD_MESSAGES; m++)
			send_message($urandom_range(3), $urandom_range(1));
		wait_drained();

		// Random messages under each flow-control mix
		run_phase(0, 0);
		run_phase(71, 0);
		run_phase(0, 71);
		run_phase(29, 29);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.words_pending() != 0) begin
			$display("%0t: %0d digest words never arrived", $time, sb.words_pending());
			sb.fail_count++;
		end
		$display("Hashed %0d messages from %0d data bytes and %0d ignored beats,",
			messages_sent, bytes_in, ignored_in);
		$display("checked %0d digest words under four stall mixes and one long sink hold-off.",
			sb.words_checked);
		if (sb.fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
